### sv/c8wd_pkg.sv
// shared types, register map and crc-8 byte update for the crc8 checked word deframer
package c8wd_pkg;

    localparam int WORD_BYTES_DEF = 2;
    localparam int APB_ADDR_W     = 4;
    localparam int APB_DATA_W     = 32;
    localparam int MAX_WORDS      = 8;

    localparam logic [7:0] CRC_INIT_RST  = 8'hFF;
    localparam logic [7:0] CRC_POLY_RST  = 8'h31;
    localparam logic [3:0] WORDS_PER_RST = 4'd2;

    // register index, byte address is 4 * index
    typedef enum logic [1:0] {
        REG_CRC_INIT   = 2'd0,
        REG_CRC_POLY   = 2'd1,
        REG_WORDS_PER  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] crc_init;
        logic [7:0] crc_poly;
        logic [3:0] words_per_frame;
    } cfg_t;

    // msb-first crc-8 over one byte, eight shift/xor steps flattened to xor logic
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ poly;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### sv/c8wd_regs.sv
// apb configuration registers of the crc8 checked word deframer
module c8wd_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [c8wd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [c8wd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [c8wd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output c8wd_pkg::cfg_t                  cfg
);
    import c8wd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_CRC_INIT:  cfg_next.crc_init        = pwdata[7:0];
                REG_CRC_POLY:  cfg_next.crc_poly        = pwdata[7:0];
                REG_WORDS_PER: cfg_next.words_per_frame = pwdata[3:0];
                default:       cfg_next                 = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CRC_INIT:  prdata = {{(APB_DATA_W-8){1'b0}}, cfg_reg.crc_init};
            REG_CRC_POLY:  prdata = {{(APB_DATA_W-8){1'b0}}, cfg_reg.crc_poly};
            REG_WORDS_PER: prdata = {{(APB_DATA_W-4){1'b0}}, cfg_reg.words_per_frame};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_init        <= CRC_INIT_RST;
            cfg_reg.crc_poly        <= CRC_POLY_RST;
            cfg_reg.words_per_frame <= WORDS_PER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/crc8_checked_word_deframer.sv
// top level of the crc8 checked word deframer: byte pipeline, crc check and result register
//
// takes one sensor response byte per request and returns one result per crc byte. a word
// is WORD_BYTES data bytes followed by a crc byte; the crc-8 (msb first, programmable
// init and polynomial, implicit x^8) runs over the data bytes and restarts from crc_init
// at every word. each result carries the big-endian word (the last two data bytes), the
// crc match flag, the word's index in the response, a running frame_ok flag and a
// last_word flag once words_per_frame words are done (0 counts as 1, above 8 as 8).
// frame_start on a byte drops any partial word and starts the response over with that
// byte. the block sustains one byte per cycle unless the input stage holds: a request is
// registered in the input stage, then the crc-8 byte update (a flattened xor network)
// and the word bookkeeping run into the result register. the input stage only holds
// when a crc byte meets a full, stalled result register. configuration goes through
// the apb port at byte addresses 0, 4 and 8; the user must write it only while no
// request is in flight, which the block itself does not enforce.
module crc8_checked_word_deframer #(
    parameter int WORD_BYTES = c8wd_pkg::WORD_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // apb configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [c8wd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [c8wd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [c8wd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // byte input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      rx_byte,
    input  logic                            frame_start,
    // word result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [15:0]                     word_value,
    output logic                            crc_ok,
    output logic [2:0]                      word_index,
    output logic                            frame_ok,
    output logic                            last_word
);
    import c8wd_pkg::*;

    localparam int PhaseW = $clog2(WORD_BYTES + 1);
    localparam logic [PhaseW-1:0] PhaseCrc = PhaseW'(WORD_BYTES);

    cfg_t cfg;

    c8wd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input stage
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_start_reg;
    logic       in_fire;
    logic       s1_adv;

    // word state
    logic [PhaseW-1:0] phase_reg, phase_next;
    logic [7:0]        crc_reg, crc_next;
    logic [7:0]        high_reg, high_next;
    logic [7:0]        low_reg, low_next;
    logic [2:0]        wc_reg, wc_next;
    logic              good_reg, good_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] res_word_reg;
    logic        res_ok_reg;
    logic [2:0]  res_idx_reg;
    logic        res_fok_reg;
    logic        res_last_reg;

    // frame-start adjusted view of the state
    logic [PhaseW-1:0] phase_eff;
    logic [2:0]        wc_eff;
    logic              good_eff;
    logic              is_crc;
    logic              out_load;
    logic [3:0]        frame_len;
    logic              word_ok;
    logic              word_fok;
    logic              word_last;

    assign phase_eff = s1_start_reg ? '0 : phase_reg;
    assign wc_eff    = s1_start_reg ? 3'd0 : wc_reg;
    assign good_eff  = s1_start_reg ? 1'b1 : good_reg;
    assign is_crc    = (phase_eff == PhaseCrc);

    // a crc byte may only leave the input stage if the result register can take it
    assign s1_adv   = s1_valid_reg && !(is_crc && out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_fire  = in_valid && !in_stall;
    assign out_load = s1_adv && is_crc;

    // clamp words_per_frame to 1..8
    always_comb
    begin
        priority if (cfg.words_per_frame == 4'd0)
            frame_len = 4'd1;
        else if (cfg.words_per_frame > 4'(MAX_WORDS))
            frame_len = 4'(MAX_WORDS);
        else
            frame_len = cfg.words_per_frame;
    end

    assign word_ok   = (crc_reg == s1_byte_reg);
    assign word_fok  = good_eff && word_ok;
    assign word_last = ({1'b0, wc_eff} + 4'd1) >= frame_len;

    // state update for the byte in the input stage
    always_comb
    begin
        phase_next = phase_reg;
        crc_next   = crc_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        wc_next    = wc_reg;
        good_next  = good_reg;
        if (s1_adv)
        begin
            wc_next   = wc_eff;
            good_next = good_eff;
            if (!is_crc)
            begin
                // data byte: crc restarts from crc_init on the first byte of a word
                if (phase_eff == '0)
                begin
                    crc_next  = crc8_byte(cfg.crc_init, s1_byte_reg, cfg.crc_poly);
                    high_next = 8'd0;
                end
                else
                begin
                    crc_next  = crc8_byte(crc_reg, s1_byte_reg, cfg.crc_poly);
                    high_next = low_reg;
                end
                low_next   = s1_byte_reg;
                phase_next = phase_eff + PhaseW'(1);
            end
            else
            begin
                // crc byte closes the word
                phase_next = '0;
                if (word_last)
                begin
                    wc_next   = 3'd0;
                    good_next = 1'b1;
                end
                else
                begin
                    wc_next   = wc_eff + 3'd1;
                    good_next = word_fok;
                end
            end
        end
    end

    always_comb
    begin
        priority if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_comb
    begin
        priority if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            crc_reg       <= CRC_INIT_RST;
            high_reg      <= 8'd0;
            low_reg       <= 8'd0;
            wc_reg        <= 3'd0;
            good_reg      <= 1'b1;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            crc_reg       <= crc_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            wc_reg        <= wc_next;
            good_reg      <= good_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg  <= rx_byte;
            s1_start_reg <= frame_start;
        end
        if (out_load)
        begin
            res_word_reg <= {high_reg, low_reg};
            res_ok_reg   <= word_ok;
            res_idx_reg  <= wc_eff;
            res_fok_reg  <= word_fok;
            res_last_reg <= word_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign word_value = res_word_reg;
    assign crc_ok     = res_ok_reg;
    assign word_index = res_idx_reg;
    assign frame_ok   = res_fok_reg;
    assign last_word  = res_last_reg;

    // input stage only holds behind a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stall without a blocked result");

    // a result that leaves with frame_ok must have matched its own crc
    a_fok_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_fok_reg) |-> res_ok_reg)
        else $error("frame_ok set on a word with a crc mismatch");

    // the last word of a response resets the word count and the frame flag
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && word_last) |=> (wc_reg == 3'd0 && good_reg && phase_reg == '0))
        else $error("word state not cleared after the last word");

    // a loaded result is not dropped while stalled
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("result lost while stalled");

endmodule
